// ===== hw/rtl/chp_pkg.sv =====
// chp_pkg: shared types and constants of the chained hash pair set
// field widths, operation and status codes, controller states, command/status bundles
// no dependencies
package chp_pkg;

  // word field widths
  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 16;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int BIDX_W   = 4;

  // key bits folded into the bucket remainder per cycle
  localparam int DIG        = 4;
  localparam int MOD_CYCLES = KEY_W / DIG;
  localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DUP      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

  // one stored slot
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } slot_t;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_BASE,
    S_SCAN,
    S_COMMIT
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clear;
    logic load;
    logic mod_step;
    logic base;
    logic scan;
    logic commit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic scan_last;
  } sts_t;

endpackage

// ===== hw/rtl/chp_if.sv =====
// chp_req_if, chp_rsp_if: valid/ready channels of the chained hash pair set
// depends on chp_pkg for field widths
interface chp_req_if;
  import chp_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [KEY_W-1:0]   pair_key;
  logic [VALUE_W-1:0] pair_value;

  modport source (output valid, output func, output pair_key, output pair_value,
                  input ready);
  modport sink   (input valid, input func, input pair_key, input pair_value,
                  output ready);
endinterface

interface chp_rsp_if;
  import chp_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BIDX_W-1:0]   bucket_index;

  modport source (output valid, output status, output bucket_index, input ready);
  modport sink   (input valid, input status, input bucket_index, output ready);
endinterface

// ===== hw/rtl/chp_ctrl.sv =====
// chp_ctrl: sequencing state machine of the chained hash pair set
// depends on chp_pkg; drives datapath commands and the result word valid flag
module chp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  input  chp_pkg::sts_t sts,
  output chp_pkg::cmd_t cmd
);
  import chp_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_free;

  // result register can take a new word
  assign out_free = !out_valid || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (sts.clr_last) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_MOD;
      S_MOD:    if (sts.mod_last) state_next = S_BASE;
      S_BASE:   state_next = S_SCAN;
      S_SCAN:   if (sts.scan_last) state_next = S_COMMIT;
      S_COMMIT: if (out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      S_CLEAR:  cmd.clear = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_MOD:    cmd.mod_step = 1'b1;
      S_BASE:   cmd.base = 1'b1;
      S_SCAN:   cmd.scan = 1'b1;
      S_COMMIT: cmd.commit = out_free;
      default:  cmd = '0;
    endcase
  end

  // result word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/chp_dp.sv =====
// chp_dp: datapath of the chained hash pair set
// depends on chp_pkg; holds the slot memory, bucket remainder unit, scan trackers
// and the result register
module chp_dp #(
  parameter int BUCKETS = 16,
  parameter int SLOTS   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  chp_pkg::cmd_t                 cmd,
  output chp_pkg::sts_t                 sts,
  input  logic [chp_pkg::FUNC_W-1:0]    func,
  input  logic [chp_pkg::KEY_W-1:0]     pair_key,
  input  logic [chp_pkg::VALUE_W-1:0]   pair_value,
  output logic [chp_pkg::STATUS_W-1:0]  status,
  output logic [chp_pkg::BIDX_W-1:0]    bucket_index
);
  import chp_pkg::*;

  localparam int DEPTH = BUCKETS * SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(BUCKETS);
  localparam int RW    = BW + 1;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCW   = $clog2(SLOTS + 1);
  localparam int BXW   = BW + BIDX_W;

  // item registers
  logic [FUNC_W-1:0]  func_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] value_q;

  // bucket remainder unit
  logic [KEY_W-1:0]     key_sh;
  logic [BW-1:0]        rem;
  logic [BW-1:0]        rem_next;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [BW-1:0]        r_tmp;
  logic [RW-1:0]        w_tmp;

  // memory and scan
  slot_t          mem [DEPTH];
  slot_t          rd_q;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           rd_vld;
  logic [SW-1:0]  rd_slot;
  logic [AW-1:0]  base;
  logic [SCW-1:0] iss_cnt;
  logic [AW-1:0]  clr_addr;
  logic           hit_found;
  logic [SW-1:0]  hit_slot;
  logic           free_found;
  logic [SW-1:0]  free_slot;
  logic           rd_match;

  // commit decision
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  slot_t               wr_data;
  logic                do_write;
  logic [SW-1:0]       wr_slot;
  slot_t               new_slot;
  logic [STATUS_W-1:0] status_next;
  logic [BXW-1:0]      bucket_ext;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= func;
      key_q   <= pair_key;
      value_q <= pair_value;
    end
  end

  // remainder by bucket count, DIG key bits per cycle, restoring steps
  always_comb begin
    r_tmp = rem;
    w_tmp = '0;
    for (int i = 0; i < DIG; i++) begin
      w_tmp = {r_tmp, key_sh[KEY_W-1-i]};
      if (w_tmp >= RW'(BUCKETS)) w_tmp = w_tmp - RW'(BUCKETS);
      r_tmp = w_tmp[BW-1:0];
    end
    rem_next = r_tmp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cnt <= '0;
    end else if (cmd.load) begin
      mod_cnt <= '0;
    end else if (cmd.mod_step) begin
      mod_cnt <= mod_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_sh <= pair_key;
      rem    <= '0;
    end else if (cmd.mod_step) begin
      key_sh <= key_sh << DIG;
      rem    <= rem_next;
    end
  end

  assign sts.mod_last = (mod_cnt == MOD_CNT_W'(MOD_CYCLES - 1));

  // bucket base address
  always_ff @(posedge clk) begin
    if (cmd.base) begin
      base <= AW'(rem) * AW'(SLOTS);
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign sts.clr_last = (clr_addr == AW'(DEPTH - 1));

  // read issue over the bucket's slots
  assign rd_en   = cmd.scan && (iss_cnt < SCW'(SLOTS));
  assign rd_addr = base + AW'(iss_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_cnt <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (cmd.base) begin
        iss_cnt <= '0;
      end else if (rd_en) begin
        iss_cnt <= iss_cnt + 1'b1;
      end
      rd_vld <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_slot <= iss_cnt[SW-1:0];
    end
  end

  // slot memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // exact pair match and first free slot trackers
  assign rd_match = rd_q.valid && (rd_q.key == key_q) && (rd_q.value == value_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_vld) begin
      if (rd_match && !hit_found) begin
        hit_found <= 1'b1;
        hit_slot  <= rd_slot;
      end
      if (!rd_q.valid && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= rd_slot;
      end
    end
  end

  assign sts.scan_last = rd_vld && (rd_slot == SW'(SLOTS - 1));

  // commit decision
  always_comb begin
    do_write       = 1'b0;
    wr_slot        = hit_slot;
    new_slot       = '0;
    status_next    = STAT_NOTFOUND;
    unique case (func_q)
      FUNC_INSERT: begin
        if (hit_found) begin
          status_next = STAT_DUP;
        end else if (!free_found) begin
          status_next = STAT_FULL;
        end else begin
          do_write       = 1'b1;
          wr_slot        = free_slot;
          new_slot.valid = 1'b1;
          new_slot.key   = key_q;
          new_slot.value = value_q;
          status_next    = STAT_DONE;
        end
      end
      FUNC_REMOVE: begin
        if (hit_found) begin
          do_write    = 1'b1;
          status_next = STAT_DONE;
        end
      end
      default: begin
        status_next = hit_found ? STAT_DONE : STAT_NOTFOUND;
      end
    endcase
  end

  // write port select: clearing pass or commit
  always_comb begin
    if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = cmd.commit && do_write;
      wr_addr = base + AW'(wr_slot);
      wr_data = new_slot;
    end
  end

  // result register
  assign bucket_ext = BXW'(rem);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status       <= status_next;
      bucket_index <= bucket_ext[BIDX_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/chained_hash_pair_set.sv =====
// chained_hash_pair_set: top level of the hash pair set with bucket chaining
// depends on chp_pkg, chp_req_if/chp_rsp_if, chp_ctrl and chp_dp
//
// Keeps (key, value) pairs in BUCKETS buckets of SLOTS slots; a pair lives in
// bucket key mod BUCKETS. Each request word inserts, finds or removes one exact
// pair (func 3 acts as find) and returns one response word with a status (done,
// duplicate, not found, bucket full) and the low four bits of the bucket number.
// After reset the block clears all BUCKETS*SLOTS slots, one slot per cycle, with
// req.ready low. Each request then passes these steps from accept to the next
// accept: the bucket remainder (four key bits a cycle), the bucket base address,
// the scan of the bucket through the single registered read port of the slot memory,
// a decide step that writes back at most one slot and loads the response register,
// and a return to idle to take the next request. The decide step is held for as long
// as the previous response still waits on rsp.ready. A new request is taken while
// the previous response still waits on rsp.ready.
module chained_hash_pair_set #(
  parameter int BUCKETS = 16,
  parameter int SLOTS   = 8
) (
  input  logic     clk,
  input  logic     rst,
  chp_req_if.sink  req,
  chp_rsp_if.source rsp
);
  import chp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  chp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage and arithmetic
  chp_dp #(
    .BUCKETS (BUCKETS),
    .SLOTS   (SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .func         (req.func),
    .pair_key     (req.pair_key),
    .pair_value   (req.pair_value),
    .status       (rsp.status),
    .bucket_index (rsp.bucket_index)
  );

  // commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.load, cmd.mod_step, cmd.base, cmd.scan, cmd.commit}))
    else $error("more than one datapath command active");

  // a commit never overwrites a response that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp.valid || rsp.ready))
    else $error("response register overwritten");

  // a commit always presents a response in the next cycle
  a_commit_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp.valid)
    else $error("commit without response");

  // no request is taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !req.ready)
    else $error("request accepted during clearing pass");

endmodule

// ===== verif/chained_hash_pair_set_tb.sv =====
// chained_hash_pair_set_tb: self-checking bench for the chained hash pair set
// drives insert/find/remove words, checks each reply against the table or a shadow store
// depends on chp_pkg, chp_req_if/chp_rsp_if and chained_hash_pair_set
module chained_hash_pair_set_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import chp_pkg::*;

  localparam int BUCKETS      = 16;
  localparam int SLOTS        = 8;
  localparam int RANDOM_WORDS = 450;
  localparam int HOT_BUCKETS  = 4;
  localparam int HOT_KEYS     = 12;
  localparam int HISTORY_MAX  = 64;
  localparam int CALM_FROM    = 220;
  localparam int CALM_TO      = 320;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 2 * (SLOTS + 8) + 8;
  localparam int CYCLE_LIMIT  = 200000;

  // func 3 has no name in the package; the block treats it as a find
  localparam logic [FUNC_W-1:0] FUNC_ALT_FIND = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [BIDX_W-1:0]   bucket;
  } reply_t;

  typedef struct {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } pair_t;

  typedef struct {
    logic [FUNC_W-1:0]   op;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;
    bit                  typed;
    logic [STATUS_W-1:0] status;
    logic [BIDX_W-1:0]   bucket;
  } dir_row_t;

  logic clk;
  logic rst;

  chp_req_if req_ch ();
  chp_rsp_if rsp_ch ();

  chained_hash_pair_set #(
    .BUCKETS(BUCKETS),
    .SLOTS  (SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  slot_t    shadow_slots [BUCKETS*SLOTS];
  reply_t   owed_replies [$];
  pair_t    pair_history [$];
  dir_row_t dir_tab [$];

  int accepted_cnt;
  int fail_cnt;
  int reply_cnt;
  int status_seen [4];
  int cycle_cnt;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d replies still owed", cycle_cnt,
             owed_replies.size());
    $display("tb: failure");
    $finish;
  end

  // stretch of the run with no idling on either side
  function automatic bit calm_window();
    return accepted_cnt >= CALM_FROM && accepted_cnt < CALM_TO;
  endfunction

  // shadow store: apply one operation and return the reply it earns
  function automatic void pair_set_step(input logic [FUNC_W-1:0] op,
                                        input logic [KEY_W-1:0] k,
                                        input logic [VALUE_W-1:0] v,
                                        output logic [STATUS_W-1:0] st,
                                        output logic [BIDX_W-1:0] bk);
    int bucket;
    int base;
    int hit;
    int spare;
    bucket = int'(k) % BUCKETS;
    base   = bucket * SLOTS;
    hit    = -1;
    spare  = -1;
    for (int s = 0; s < SLOTS; s++) begin
      if (hit < 0 && shadow_slots[base+s].valid && shadow_slots[base+s].key == k &&
          shadow_slots[base+s].value == v)
        hit = s;
      if (spare < 0 && !shadow_slots[base+s].valid)
        spare = s;
    end
    bk = BIDX_W'(bucket);
    case (op)
      FUNC_INSERT: begin
        if (hit >= 0) begin
          st = STAT_DUP;
        end else if (spare < 0) begin
          st = STAT_FULL;
        end else begin
          shadow_slots[base+spare] = '{valid: 1'b1, key: k, value: v};
          st = STAT_DONE;
        end
      end
      FUNC_REMOVE: begin
        if (hit >= 0) begin
          shadow_slots[base+hit] = '0;
          st = STAT_DONE;
        end else begin
          st = STAT_NOTFOUND;
        end
      end
      default: begin
        st = (hit >= 0) ? STAT_DONE : STAT_NOTFOUND;
      end
    endcase
  endfunction

  task automatic add_row(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k,
                         input logic [VALUE_W-1:0] v, input bit typed,
                         input logic [STATUS_W-1:0] st, input logic [BIDX_W-1:0] bk);
    dir_tab.push_back('{op: op, key: k, value: v, typed: typed, status: st, bucket: bk});
  endtask

  // directed words: empty store, extremes, duplicates, a full bucket, refill
  task automatic build_table();
    add_row(FUNC_FIND,     16'h0000, 16'h0000, 1, STAT_NOTFOUND, 4'd0);
    add_row(FUNC_REMOVE,   16'hFFFF, 16'hFFFF, 1, STAT_NOTFOUND, 4'd15);
    add_row(FUNC_INSERT,   16'h0000, 16'h0000, 1, STAT_DONE,     4'd0);
    add_row(FUNC_INSERT,   16'h0000, 16'h0000, 1, STAT_DUP,      4'd0);
    add_row(FUNC_FIND,     16'h0000, 16'h0000, 1, STAT_DONE,     4'd0);
    add_row(FUNC_ALT_FIND, 16'h0000, 16'h0000, 1, STAT_DONE,     4'd0);
    add_row(FUNC_FIND,     16'h0000, 16'h0001, 1, STAT_NOTFOUND, 4'd0);
    add_row(FUNC_FIND,     16'h0010, 16'h0000, 1, STAT_NOTFOUND, 4'd0);
    add_row(FUNC_INSERT,   16'hFFFF, 16'hFFFF, 1, STAT_DONE,     4'd15);
    // fill bucket 5 with eight different keys
    for (int n = 0; n < SLOTS; n++)
      add_row(FUNC_INSERT, KEY_W'(5 + BUCKETS * n), 16'hA5A5 ^ VALUE_W'(n), 0,
              STAT_DONE, 4'd5);
    add_row(FUNC_INSERT,   KEY_W'(5 + BUCKETS * SLOTS), 16'h5A5A, 1, STAT_FULL, 4'd5);
    // duplicate check wins over the full flag
    add_row(FUNC_INSERT,   16'h0005, 16'hA5A5, 1, STAT_DUP,  4'd5);
    add_row(FUNC_REMOVE,   KEY_W'(5 + BUCKETS * 2), 16'hA5A7, 1, STAT_DONE, 4'd5);
    add_row(FUNC_INSERT,   KEY_W'(5 + BUCKETS * SLOTS), 16'h5A5A, 0, STAT_DONE, 4'd5);
    add_row(FUNC_FIND,     KEY_W'(5 + BUCKETS * SLOTS), 16'h5A5A, 0, STAT_DONE, 4'd5);
    add_row(FUNC_REMOVE,   16'h0000, 16'h0000, 1, STAT_DONE,     4'd0);
    add_row(FUNC_FIND,     16'h0000, 16'h0000, 1, STAT_NOTFOUND, 4'd0);
    add_row(FUNC_ALT_FIND, 16'hFFFF, 16'h0000, 1, STAT_NOTFOUND, 4'd15);
  endtask

  // random word: mostly keys packed into a few buckets so they fill and overflow
  task automatic pick_random_word(output logic [FUNC_W-1:0] op,
                                  output logic [KEY_W-1:0] k,
                                  output logic [VALUE_W-1:0] v);
    int r;
    int sel;
    int idx;
    r   = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    if (r < 40)      op = FUNC_INSERT;
    else if (r < 70) op = FUNC_FIND;
    else if (r < 95) op = FUNC_REMOVE;
    else             op = FUNC_ALT_FIND;
    if (sel < 25 && pair_history.size() > 0) begin
      idx = $urandom_range(0, pair_history.size() - 1);
      k   = pair_history[idx].key;
      v   = pair_history[idx].value;
    end else if (sel < 85) begin
      k = KEY_W'($urandom_range(0, HOT_BUCKETS - 1) +
                 BUCKETS * $urandom_range(0, HOT_KEYS - 1));
      v = VALUE_W'($urandom_range(0, 3));
    end else begin
      k = KEY_W'($urandom);
      v = VALUE_W'($urandom);
    end
  endtask

  // offer one word and wait for its handshake
  task automatic offer_word(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k,
                            input logic [VALUE_W-1:0] v);
    req_ch.valid      <= 1'b1;
    req_ch.func       <= op;
    req_ch.pair_key   <= k;
    req_ch.pair_value <= v;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    accepted_cnt++;
  endtask

  // sender idling
  task automatic idle_gap();
    if (!calm_window() && $urandom_range(0, 99) < 20) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // request side and end of run
  initial begin : word_source
    logic [FUNC_W-1:0]   op;
    logic [KEY_W-1:0]    k;
    logic [VALUE_W-1:0]  v;
    logic [STATUS_W-1:0] st;
    logic [BIDX_W-1:0]   bk;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.func       = FUNC_FIND;
    req_ch.pair_key   = '0;
    req_ch.pair_value = '0;
    accepted_cnt      = 0;
    fail_cnt          = 0;
    reply_cnt         = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;
    build_table();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_tab[i]) begin
      offer_word(dir_tab[i].op, dir_tab[i].key, dir_tab[i].value);
      pair_set_step(dir_tab[i].op, dir_tab[i].key, dir_tab[i].value, st, bk);
      if (dir_tab[i].typed)
        owed_replies.push_back('{status: dir_tab[i].status, bucket: dir_tab[i].bucket});
      else
        owed_replies.push_back('{status: st, bucket: bk});
      idle_gap();
    end

    // random words
    repeat (RANDOM_WORDS) begin
      pick_random_word(op, k, v);
      offer_word(op, k, v);
      pair_set_step(op, k, v, st, bk);
      owed_replies.push_back('{status: st, bucket: bk});
      if (op == FUNC_INSERT) begin
        pair_history.push_back('{key: k, value: v});
        if (pair_history.size() > HISTORY_MAX) void'(pair_history.pop_front());
      end
      idle_gap();
    end
    req_ch.valid <= 1'b0;

    // drain
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d words in %0d cycles, %0d replies checked", accepted_cnt,
             cycle_cnt, reply_cnt);
    $display("replies by status: done %0d, duplicate %0d, not found %0d, full %0d",
             status_seen[STAT_DONE], status_seen[STAT_DUP], status_seen[STAT_NOTFOUND],
             status_seen[STAT_FULL]);
    if (fail_cnt == 0 && owed_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // reply side: check each accepted word, then pick ready for the next cycle
  initial begin : reply_sink
    int     hold_left;
    bit     hold_done;
    reply_t want;
    hold_left    = 0;
    hold_done    = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        reply_cnt++;
        if (owed_replies.size() == 0) begin
          $display("%0t: reply with none owed: status %0d bucket %0d", $time,
                   rsp_ch.status, rsp_ch.bucket_index);
          fail_cnt++;
        end else begin
          want = owed_replies.pop_front();
          status_seen[want.status]++;
          if (rsp_ch.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                     want.status, rsp_ch.status);
            fail_cnt++;
          end
          if (rsp_ch.bucket_index !== want.bucket) begin
            $display("%0t: bucket_index mismatch: expected %0d, actual %0d", $time,
                     want.bucket, rsp_ch.bucket_index);
            fail_cnt++;
          end
        end
      end

      // one long hold-off so the block backs up and stalls its input
      if (!hold_done && accepted_cnt >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (calm_window()) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= 20);
      end
    end
  end

endmodule
